FILE: rtl/core/pi_regulator_milli_gain_unit_assert.svh
// ----------------------------------------------------------------------------
// pi_regulator_milli_gain_unit assertion macros
// Concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PI_REGULATOR_MILLI_GAIN_UNIT_ASSERT_SVH
`define PI_REGULATOR_MILLI_GAIN_UNIT_ASSERT_SVH

// same-cycle implication
`define PRMG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRMG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/prmg_pkg.sv
// ----------------------------------------------------------------------------
// prmg_pkg
// Types and constants shared by the PI regulator blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prmg_pkg;

	localparam int ERROR_WIDTH = 16;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int DVD_W       = 50;
	localparam int DIV_ITERS   = DVD_W / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_ITERS);

	localparam logic [GAIN_W-1:0]    MILLI        = GAIN_W'(1000);
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 1'b1;

	localparam logic CMD_APPLY  = 1'b0;
	localparam logic CMD_PRESET = 1'b1;

	typedef struct packed {
		logic                          cmd;
		logic signed [ERROR_WIDTH-1:0] error_sample;
		logic signed [31:0]            offset_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic add;
		logic div_load;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic is_preset;
	} dp_status_t;

endpackage

FILE: rtl/core/prmg_ctrl.sv
// ----------------------------------------------------------------------------
// prmg_ctrl
// Sequencer: multiply, accumulate (apply items only), divide and finish steps per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prmg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  prmg_pkg::dp_status_t status,
	output prmg_pkg::dp_cmd_t   cmd
);
	import prmg_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL_A = 7'b0000010,
		ST_MUL_B = 7'b0000100,
		ST_ADD   = 7'b0001000,
		ST_LOAD  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t                 state_q, state_d;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   out_valid_q;
	logic                   fin_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign fin_go    = (state_q == ST_FIN) &&
		(status.is_preset || !out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d   = status.is_preset ? ST_LOAD : ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin_go && !status.is_preset) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/prmg_datapath.sv
// ----------------------------------------------------------------------------
// prmg_datapath
// Gain registers, integrator, shared multiplier, radix-4 restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prmg_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prmg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prmg_pkg::GAIN_W-1:0]    cfg_data,
	input  prmg_pkg::in_item_t            in_data,
	input  prmg_pkg::dp_cmd_t             cmd,
	output prmg_pkg::dp_status_t          status,
	output prmg_pkg::out_item_t           out_data
);
	import prmg_pkg::*;

	localparam int OPA_W  = GAIN_W + 1;
	localparam int ACC_W  = OPA_W + 32;
	localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(64'h7FFF_FFFF);
	localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'h8000_0000);

	function automatic logic [GAIN_W:0] div_bit(input logic [GAIN_W-1:0] rem,
		input logic nb, input logic [GAIN_W-1:0] d);
		logic [GAIN_W:0] t;
		begin
			t = {rem, nb};
			if (t >= {1'b0, d}) begin
				div_bit = {1'b1, GAIN_W'(t - {1'b0, d})};
			end else begin
				div_bit = {1'b0, t[GAIN_W-1:0]};
			end
		end
	endfunction

	logic [GAIN_W-1:0]       kp_q, ki_q;
	logic signed [31:0]      integ_q;
	logic                    cmd_q;
	logic signed [31:0]      err_q;
	logic signed [31:0]      off_q;
	logic signed [ACC_W-1:0] prod_q, acc_q;
	logic                    neg_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [GAIN_W-1:0]       rem_q, dsr_q;
	logic signed [31:0]      drive_q;
	logic                    sat_q;

	logic signed [OPA_W-1:0] opa;
	logic signed [31:0]      opb;
	logic signed [ACC_W-1:0] prod;
	logic [ACC_W-1:0]        mag;
	logic [GAIN_W:0]         s1, s2;
	logic                    q_sat;
	logic signed [31:0]      q_clip;
	logic signed [32:0]      isum;
	logic                    i_sat;
	logic signed [31:0]      i_clip;

	assign status.is_preset = cmd_q;
	assign out_data.drive     = drive_q;
	assign out_data.saturated = sat_q;

	always_comb begin
		if (cmd.mul_b) begin
			opa = $signed({1'b0, ki_q});
			opb = integ_q;
		end else if (cmd_q == CMD_PRESET) begin
			opa = $signed({1'b0, MILLI});
			opb = off_q;
		end else begin
			opa = $signed({1'b0, kp_q});
			opb = err_q;
		end
		prod = opa * opb;
	end

	assign mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign s1  = div_bit(rem_q, dvd_q[DVD_W-1], dsr_q);
	assign s2  = div_bit(s1[GAIN_W-1:0], dvd_q[DVD_W-2], dsr_q);

	always_comb begin
		q_sat  = 1'b0;
		q_clip = neg_q ? -$signed(dvd_q[31:0]) : $signed(dvd_q[31:0]);
		if (!neg_q && (dvd_q > POS_LIM)) begin
			q_sat  = 1'b1;
			q_clip = 32'sh7FFF_FFFF;
		end else if (neg_q && (dvd_q > NEG_LIM)) begin
			q_sat  = 1'b1;
			q_clip = 32'sh8000_0000;
		end
		isum   = {integ_q[31], integ_q} + {err_q[31], err_q};
		i_sat  = isum[32] != isum[31];
		i_clip = i_sat ? (isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : isum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= MILLI;
			ki_q    <= MILLI;
			integ_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PROP_GAIN:  kp_q <= cfg_data;
					REG_INTEG_GAIN: ki_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.finish) begin
				if (cmd_q == CMD_PRESET) begin
					integ_q <= (dsr_q == '0) ? '0 : q_clip;
				end else begin
					integ_q <= i_clip;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_data.cmd;
			err_q <= 32'(in_data.error_sample);
			off_q <= in_data.offset_value;
		end
		if (cmd.mul_a || cmd.mul_b) begin
			prod_q <= prod;
		end
		if (cmd.mul_b) begin
			acc_q <= prod_q;
		end else if (cmd.add) begin
			acc_q <= acc_q + prod_q;
		end
		if (cmd.div_load) begin
			neg_q <= acc_q[ACC_W-1];
			dvd_q <= DVD_W'(mag);
			rem_q <= '0;
			dsr_q <= (cmd_q == CMD_PRESET) ? ki_q : MILLI;
		end else if (cmd.div_step) begin
			rem_q <= s2[GAIN_W-1:0];
			dvd_q <= {dvd_q[DVD_W-3:0], s1[GAIN_W], s2[GAIN_W]};
		end
		if (cmd.finish && (cmd_q == CMD_APPLY)) begin
			drive_q <= q_clip;
			sat_q   <= q_sat | i_sat;
		end
	end

endmodule

FILE: rtl/core/pi_regulator_milli_gain_unit.sv
// An apply item gives one result; a preset item gives none. One item at a time:
// the next item is accepted in the cycle after the previous one finishes, and
// the shared restoring divider works through 25 two-bit steps per item.
// Reset clears the integrator and sets both gains to 1000.
// ----------------------------------------------------------------------------
// pi_regulator_milli_gain_unit
// PI regulator with gains in thousandths, saturating drive and integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pi_regulator_milli_gain_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [prmg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prmg_pkg::GAIN_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  prmg_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output prmg_pkg::out_item_t            out_data
);
	import prmg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	prmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	prmg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/core/prmg_checker.sv
// ----------------------------------------------------------------------------
// prmg_checker
// Port-level checks on the PI regulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pi_regulator_milli_gain_unit_assert.svh"

module prmg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input prmg_pkg::out_item_t            out_data
);
	import prmg_pkg::*;

	`PRMG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item dropped or changed while stalled")
	`PRMG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while previous item in flight")
	`PRMG_ASSERT_SAME(a_result_at_idle, $rose(out_valid), in_ready, "result raised while still busy")
	`PRMG_ASSERT_NEXT(a_idle_holds, in_ready && !in_valid, in_ready, "left idle without an item")

endmodule

bind pi_regulator_milli_gain_unit prmg_checker u_prmg_checker (.*);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PI regulator. Items go in through a burst/gap
// driver, results are checked in order against a cycle-free predictor of the
// gain, integrator and saturation arithmetic, across several gain settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import prmg_pkg::*;

	localparam int     HOLD_CYCLES   = 400;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     RAND_PHASES   = 8;
	localparam int     PHASE_ITEMS   = 85;
	localparam longint LIMIT_NS      = 64'd5_000_000;
	localparam longint S32_MAX       = 64'sd2147483647;
	localparam longint S32_MIN       = -64'sd2147483647 - 1;
	localparam longint THOUSAND      = 1000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;

	// predictor state
	longint prop_gain_m  = 1000;
	longint integ_gain_m = 1000;
	longint integ_acc    = 0;

	in_item_t  pending_items[$];
	out_item_t expected_drives[$];
	int        queued_items   = 0;
	int        accepted_items = 0;
	int        mismatch_count = 0;

	// driver
	logic in_fire      = 1'b0;
	int   burst_left   = 1;
	int   gap_left     = 0;
	bit   steady       = 1'b0;

	// receiver
	logic [15:0] ready_pattern = 16'hFFFF;
	logic [3:0]  ready_phase   = '0;
	int          hold_left     = 0;
	int          hold_requests = 0;
	int          hold_served   = 0;

	always #5 clk = ~clk;

	pi_regulator_milli_gain_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	function automatic longint clamp_s32(input longint v, inout bit hit);
		if (v > S32_MAX) begin
			hit = 1'b1;
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			hit = 1'b1;
			return S32_MIN;
		end
		return v;
	endfunction

	// returns 1 when the item gives a result
	function automatic bit regulate_item(input in_item_t it, output out_item_t res);
		bit     hit = 1'b0;
		longint err;
		longint sum;
		longint drv;
		res = '0;
		if (it.cmd == CMD_PRESET) begin
			if (integ_gain_m == 0)
				integ_acc = 0;
			else
				integ_acc = clamp_s32((longint'(it.offset_value) * THOUSAND) / integ_gain_m, hit);
			return 1'b0;
		end
		err = longint'(it.error_sample);
		sum = prop_gain_m * err + integ_gain_m * integ_acc;
		drv = clamp_s32(sum / THOUSAND, hit);
		integ_acc = clamp_s32(integ_acc + err, hit);
		res.drive = drv[31:0];
		res.saturated = hit;
		return 1'b1;
	endfunction

	function automatic in_item_t apply_item(input logic signed [ERROR_WIDTH-1:0] e);
		in_item_t it;
		it.cmd = CMD_APPLY;
		it.error_sample = e;
		it.offset_value = $urandom();
		return it;
	endfunction

	function automatic in_item_t preset_item(input logic signed [31:0] o);
		in_item_t it;
		it.cmd = CMD_PRESET;
		it.error_sample = ERROR_WIDTH'($urandom());
		it.offset_value = o;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       near;
		it.cmd = ($urandom_range(0, 99) < 15) ? CMD_PRESET : CMD_APPLY;
		near = int'($urandom_range(0, 200)) - 100;
		case ($urandom_range(0, 9))
			0: it.error_sample = {1'b0, {(ERROR_WIDTH-1){1'b1}}};
			1: it.error_sample = {1'b1, {(ERROR_WIDTH-1){1'b0}}};
			2, 3, 4: it.error_sample = near[ERROR_WIDTH-1:0];
			default: it.error_sample = ERROR_WIDTH'($urandom());
		endcase
		near = int'($urandom_range(0, 2_000_000)) - 1_000_000;
		case ($urandom_range(0, 7))
			0: it.offset_value = 32'sh7FFF_FFFF;
			1: it.offset_value = 32'sh8000_0000;
			2, 3: it.offset_value = near;
			default: it.offset_value = $urandom();
		endcase
		return it;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return GAIN_W'(1000);
			3: return GAIN_W'(1);
			default: return GAIN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PROP_GAIN)
			prop_gain_m = longint'(val);
		else
			integ_gain_m = longint'(val);
	endtask

	task automatic push_item(input in_item_t it);
		pending_items.push_back(it);
		queued_items++;
	endtask

	// a preset gives no result, so let the block settle after the last one
	task automatic drain();
		while (accepted_items != queued_items || expected_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic shape_idling(input bit calm);
		steady = calm;
		ready_pattern = calm ? 16'hFFFF : (16'($urandom()) | 16'h0001);
	endtask

	// sender: bursts and gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (pending_items.size() != 0) begin
			in_data <= pending_items.pop_front();
			in_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 12);
				gap_left <= steady ? 0 : (($urandom_range(0, 3) == 0) ?
					$urandom_range(4, 35) : $urandom_range(0, 3));
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: own stall pattern, plus long hold-offs on request
	always @(negedge clk) begin
		ready_phase <= ready_phase + 1'b1;
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ready_pattern[ready_phase];
		end
	end

	always @(posedge clk) begin : check_block
		out_item_t predicted;
		out_item_t oldest;
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			accepted_items++;
			if (regulate_item(in_data, predicted))
				expected_drives.push_back(predicted);
		end
		if (out_valid && out_ready) begin
			if (expected_drives.size() == 0) begin
				$error("result with none expected: drive %0d saturated %0b",
					$signed(out_data.drive), out_data.saturated);
				mismatch_count++;
			end else begin
				oldest = expected_drives.pop_front();
				if (out_data.drive !== oldest.drive) begin
					$error("drive: expected %0d, actual %0d",
						$signed(oldest.drive), $signed(out_data.drive));
					mismatch_count++;
				end
				if (out_data.saturated !== oldest.saturated) begin
					$error("saturated: expected %0b, actual %0b",
						oldest.saturated, out_data.saturated);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gains: field extremes, integrator and drive clipping
		shape_idling(1'b1);
		push_item(apply_item(16'sd0));
		push_item(apply_item(16'sh7FFF));
		push_item(apply_item(16'sh8000));
		push_item(apply_item(-16'sd1));
		push_item(apply_item(16'sd1));
		push_item(preset_item(32'sh7FFF_FFFF));
		push_item(apply_item(16'sh7FFF));
		push_item(preset_item(32'sh8000_0000));
		push_item(apply_item(16'sh8000));
		push_item(preset_item(32'sd0));
		push_item(apply_item(16'sd0));
		drain();

		// tiny integral gain: preset quotient out of range
		write_gain(REG_PROP_GAIN, 16'hFFFF);
		write_gain(REG_INTEG_GAIN, 16'd1);
		shape_idling(1'b0);
		push_item(preset_item(32'sh7FFF_FFFF));
		push_item(apply_item(16'sh7FFF));
		push_item(preset_item(32'sh8000_0000));
		push_item(apply_item(16'sh8000));
		drain();

		// full integral gain on a clipped integrator: drive overflow
		write_gain(REG_INTEG_GAIN, 16'hFFFF);
		push_item(apply_item(16'sd0));
		push_item(preset_item(32'sh7FFF_FFFF));
		push_item(apply_item(16'sh7FFF));
		drain();

		// zero gains: preset clears the integrator
		write_gain(REG_PROP_GAIN, 16'd0);
		write_gain(REG_INTEG_GAIN, 16'd0);
		push_item(preset_item(32'sd12345));
		push_item(apply_item(16'sd100));
		push_item(preset_item(-32'sd7));
		push_item(apply_item(16'sh8000));
		drain();

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			kp = (phase == 0) ? 16'd0 : (phase == 1) ? 16'hFFFF : pick_gain();
			ki = (phase == 0) ? 16'hFFFF : (phase == 1) ? 16'd0 : pick_gain();
			write_gain(REG_PROP_GAIN, kp);
			write_gain(REG_INTEG_GAIN, ki);
			shape_idling(phase == 3);
			if (phase == 1 || phase == 6)
				hold_requests++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender runs dry and waits until every outstanding result is back
				if (phase == 4 && n == PHASE_ITEMS / 2) begin
					while (accepted_items != queued_items ||
						expected_drives.size() != 0)
						@(posedge clk);
				end
				push_item(random_item());
			end
			drain();
		end

		if (mismatch_count == 0 && expected_drives.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (expected_drives.size() != 0)
				$error("%0d expected results never arrived", expected_drives.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
